// ----- rtl/core/kts_pkg.sv -----
// Shared types and fixed constants of the trajectory smoother.
package kts_pkg;

  // Field widths fixed by the interface
  localparam int unsigned SHIFT_W   = 32;
  localparam int unsigned SMOOTH_W  = 48;
  localparam int unsigned NOISE_W   = 32;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned NUM_AXES  = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE = CFG_IDX_W'(1);

  // Noise reset values in Q2.30, scaled down for fewer fraction bits
  localparam int unsigned       RESET_FRAC_BITS = 30;
  localparam logic [NOISE_W-1:0] Q_RESET_Q30    = 32'd4294967;
  localparam logic [NOISE_W-1:0] R_RESET_Q30    = 32'd268435456;

  // Control of a bit-serial arithmetic unit
  typedef struct packed {
    logic load;
    logic step;
  } ctl_t;

endpackage

// ----- rtl/core/kts_serial_div.sv -----
// Restoring divider producing one quotient bit per cycle while step is set.
module kts_serial_div #(
  parameter int unsigned NUM_W = 32,
  parameter int unsigned DEN_W = 33,
  parameter int unsigned Q_W   = 31
) (
  input  logic               clk,
  input  kts_pkg::ctl_t      ctl,
  input  logic [NUM_W-1:0]   num,
  input  logic [DEN_W-1:0]   den,
  output logic [Q_W-1:0]     quot
);
  import kts_pkg::*;

  logic [DEN_W:0]   rem_r;
  logic [Q_W-1:0]   quot_r;
  logic             ge;
  logic [DEN_W:0]   sub;
  logic [DEN_W:0]   kept;

  // Trial subtract of the divisor from the partial remainder
  always_comb begin
    ge   = (rem_r >= {1'b0, den});
    sub  = rem_r - {1'b0, den};
    kept = ge ? sub : rem_r;
  end

  // Load the numerator, then shift one quotient bit in per step
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rem_r  <= (DEN_W+1)'(num);
      quot_r <= '0;
    end else if (ctl.step) begin
      rem_r  <= {kept[DEN_W-1:0], 1'b0};
      quot_r <= {quot_r[Q_W-2:0], ge};
    end
  end

  assign quot = quot_r;

endmodule

// ----- rtl/core/kts_mul_lane.sv -----
// Shift-add multiplier lane consuming one multiplier bit per cycle while step is set.
module kts_mul_lane #(
  parameter int unsigned A_W = 48,
  parameter int unsigned B_W = 31
) (
  input  logic                 clk,
  input  kts_pkg::ctl_t        ctl,
  input  logic [A_W-1:0]       mcand,
  input  logic [B_W-1:0]       mplier,
  output logic [A_W+B_W-1:0]   prod
);
  import kts_pkg::*;

  localparam int unsigned P_W = A_W + B_W;

  logic [P_W-1:0] acc_r;
  logic [A_W-1:0] mcand_r;
  logic [A_W:0]   sum;

  // Add the multiplicand into the upper half when the low bit is set
  always_comb begin
    sum = {1'b0, acc_r[P_W-1 -: A_W]} + (acc_r[0] ? {1'b0, mcand_r} : '0);
  end

  // Multiplier sits in the low half and drains out as the product shifts in
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      acc_r   <= {{A_W{1'b0}}, mplier};
      mcand_r <= mcand;
    end else if (ctl.step) begin
      acc_r <= {sum, acc_r[B_W-1:1]};
    end
  end

  assign prod = acc_r;

endmodule

// ----- rtl/core/kalman_trajectory_smoother_top.sv -----
// Top level of the Kalman trajectory smoother.
//
// Usage: one transaction on the in_ channel carries a frame-to-frame motion
// (shift x, shift y, angle, signed Q16.16). The block adds it into the raw
// trajectory, runs one scalar Kalman update shared by the three axes and
// returns one transaction on the out_ channel with the corrected motion
// (saturated to 32 bits, clipped flag) and the smoothed trajectory.
// A frame passes through the prepare, divide, load, multiply, update,
// difference and final states; the first frame after reset skips the filter
// and goes from prepare straight to update. A new input is taken only once
// the frame has left the final state. The restoring divider for the gain and
// the shift-add multiplier lanes both retire one bit of the gain per cycle.
// in_stall is high while a frame is in progress. A finished result waits in
// the output register; while out_stall holds it, the next result waits in
// its final state and no further input is taken.
// Configuration writes are taken only between frames with in_valid low.
// Reset clears trajectory and estimate, sets the variance to one and loads
// the default noise values; the first frame after reset only primes the
// filter.
module kalman_trajectory_smoother_top #(
  parameter int unsigned COV_FRAC_BITS = 30,
  parameter int unsigned ACC_WIDTH     = 48
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // input channel
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [kts_pkg::SHIFT_W-1:0]     in_shift_x,
  input  logic signed [kts_pkg::SHIFT_W-1:0]     in_shift_y,
  input  logic signed [kts_pkg::SHIFT_W-1:0]     in_shift_angle,
  // result channel
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [kts_pkg::SHIFT_W-1:0]     out_corrected_x,
  output logic signed [kts_pkg::SHIFT_W-1:0]     out_corrected_y,
  output logic signed [kts_pkg::SHIFT_W-1:0]     out_corrected_angle,
  output logic signed [kts_pkg::SMOOTH_W-1:0]    out_smooth_x,
  output logic signed [kts_pkg::SMOOTH_W-1:0]    out_smooth_y,
  output logic signed [kts_pkg::SMOOTH_W-1:0]    out_smooth_angle,
  output logic                                   out_clipped,
  // configuration write channel
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [kts_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [kts_pkg::NOISE_W-1:0]            cfg_data
);
  import kts_pkg::*;

  localparam int unsigned K_W   = COV_FRAC_BITS + 1;
  localparam int unsigned CNT_W = $clog2(COV_FRAC_BITS + 1);
  localparam int unsigned DEN_W = NOISE_W + 1;
  localparam int unsigned DEV_W = ACC_WIDTH + 1;
  localparam int unsigned COR_W = ACC_WIDTH + 2;

  localparam logic [K_W-1:0]     ONE_K   = K_W'(1) << COV_FRAC_BITS;
  localparam logic [NOISE_W-1:0] ONE_VAR = NOISE_W'(1) << COV_FRAC_BITS;
  localparam logic [NOISE_W-1:0] Q_RESET =
    NOISE_W'(Q_RESET_Q30 >> (RESET_FRAC_BITS - COV_FRAC_BITS));
  localparam logic [NOISE_W-1:0] R_RESET =
    NOISE_W'(R_RESET_Q30 >> (RESET_FRAC_BITS - COV_FRAC_BITS));
  localparam logic [CNT_W-1:0]   CNT_LAST = CNT_W'(COV_FRAC_BITS);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_PREP = 8'b0000_0010,
    S_DIV  = 8'b0000_0100,
    S_LOAD = 8'b0000_1000,
    S_MUL  = 8'b0001_0000,
    S_UPD  = 8'b0010_0000,
    S_DIFF = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } state_t;

  // Control state
  state_t                       state_r, state_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic                         out_valid_r;
  logic                         started_r;
  logic [NOISE_W-1:0]           q_noise_r;
  logic [NOISE_W-1:0]           r_noise_r;
  logic signed [ACC_WIDTH-1:0]  path_r [NUM_AXES];
  logic signed [ACC_WIDTH-1:0]  est_r  [NUM_AXES];
  logic [NOISE_W-1:0]           ev_r;

  // Working registers
  logic signed [SHIFT_W-1:0]    shift_r [NUM_AXES];
  logic [NOISE_W-1:0]           pp_r;
  logic [DEN_W-1:0]             den_r;
  logic signed [ACC_WIDTH-1:0]  res_r [NUM_AXES];
  logic [ACC_WIDTH-1:0]         mag_r [NUM_AXES];
  logic                         neg_r [NUM_AXES];
  logic [K_W-1:0]               k_r;
  logic signed [DEV_W-1:0]      dev_r [NUM_AXES];

  // Output register
  logic signed [SHIFT_W-1:0]    out_corr_r   [NUM_AXES];
  logic signed [SMOOTH_W-1:0]   out_smooth_r [NUM_AXES];
  logic                         out_clip_r;

  // Combinational
  logic                         in_fire;
  logic                         out_free;
  logic                         cnt_last;
  logic signed [SHIFT_W-1:0]    shift_in [NUM_AXES];
  logic [NOISE_W:0]             pp_sum;
  logic [NOISE_W-1:0]           pp_sat;
  logic [DEV_W-1:0]             res_full [NUM_AXES];
  logic signed [ACC_WIDTH-1:0]  res_sat  [NUM_AXES];
  logic [K_W-1:0]               quot;
  logic [K_W-1:0]               k_sel;
  logic [K_W-1:0]               k_comp;
  logic [ACC_WIDTH+K_W-1:0]     prod_ax [NUM_AXES];
  logic [NOISE_W+K_W-1:0]       prod_var;
  logic [ACC_WIDTH-1:0]         step_d [NUM_AXES];
  logic signed [COR_W-1:0]      cor_full [NUM_AXES];
  logic                         cor_fit  [NUM_AXES];
  logic signed [SHIFT_W-1:0]    cor_sat  [NUM_AXES];
  logic                         clip_any;
  ctl_t                         div_ctl;
  ctl_t                         mul_ctl;

  assign shift_in[0] = in_shift_x;
  assign shift_in[1] = in_shift_y;
  assign shift_in[2] = in_shift_angle;

  assign in_stall  = (state_r != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign cfg_ready = (state_r == S_IDLE) && !in_valid;
  assign out_free  = !out_valid_r || !out_stall;
  assign cnt_last  = (cnt_r == CNT_LAST);

  // Predicted variance, held at the top of its range
  always_comb begin
    pp_sum = {1'b0, ev_r} + {1'b0, q_noise_r};
    pp_sat = pp_sum[NOISE_W] ? '1 : pp_sum[NOISE_W-1:0];
  end

  // Residuals saturated to the trajectory range
  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      res_full[i] = {path_r[i][ACC_WIDTH-1], path_r[i]} -
                    {est_r[i][ACC_WIDTH-1], est_r[i]};
      if (res_full[i][ACC_WIDTH] != res_full[i][ACC_WIDTH-1]) begin
        res_sat[i] = res_full[i][ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                                            : {1'b0, {(ACC_WIDTH-1){1'b1}}};
      end else begin
        res_sat[i] = res_full[i][ACC_WIDTH-1:0];
      end
    end
  end

  // Gain, forced to zero on a zero denominator
  always_comb begin
    k_sel  = (den_r == '0) ? '0 : quot;
    k_comp = ONE_K - k_sel;
  end

  // Estimate steps and saturated corrected motion
  always_comb begin
    clip_any = 1'b0;
    for (int i = 0; i < NUM_AXES; i++) begin
      step_d[i]   = prod_ax[i][COV_FRAC_BITS +: ACC_WIDTH];
      cor_full[i] = COR_W'(dev_r[i]) + COR_W'(shift_r[i]);
      cor_fit[i]  = (&cor_full[i][COR_W-1:SHIFT_W-1]) ||
                    !(|cor_full[i][COR_W-1:SHIFT_W-1]);
      if (cor_fit[i]) begin
        cor_sat[i] = cor_full[i][SHIFT_W-1:0];
      end else begin
        cor_sat[i] = cor_full[i][COR_W-1] ? {1'b1, {(SHIFT_W-1){1'b0}}}
                                          : {1'b0, {(SHIFT_W-1){1'b1}}};
      end
      clip_any = clip_any || !cor_fit[i];
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = S_PREP;
      end
      S_PREP: begin
        cnt_nxt   = '0;
        state_nxt = started_r ? S_DIV : S_UPD;
      end
      S_DIV: begin
        if (cnt_last) begin
          cnt_nxt   = '0;
          state_nxt = S_LOAD;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_LOAD: begin
        state_nxt = S_MUL;
      end
      S_MUL: begin
        if (cnt_last) begin
          cnt_nxt   = '0;
          state_nxt = S_UPD;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_UPD:  state_nxt = S_DIFF;
      S_DIFF: state_nxt = S_FIN;
      S_FIN: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign div_ctl.load = (state_r == S_PREP);
  assign div_ctl.step = (state_r == S_DIV);
  assign mul_ctl.load = (state_r == S_LOAD);
  assign mul_ctl.step = (state_r == S_MUL);

  // Gain divider: Pp * 2^F / (Pp + R)
  kts_serial_div #(
    .NUM_W (NOISE_W),
    .DEN_W (DEN_W),
    .Q_W   (K_W)
  ) u_div (
    .clk  (clk),
    .ctl  (div_ctl),
    .num  (pp_r),
    .den  (den_r),
    .quot (quot)
  );

  // One multiplier lane per axis for |residual| * K
  for (genvar g = 0; g < NUM_AXES; g++) begin : g_axis
    kts_mul_lane #(
      .A_W (ACC_WIDTH),
      .B_W (K_W)
    ) u_lane (
      .clk    (clk),
      .ctl    (mul_ctl),
      .mcand  (mag_r[g]),
      .mplier (k_sel),
      .prod   (prod_ax[g])
    );
  end

  // Variance lane for (1 - K) * Pp
  kts_mul_lane #(
    .A_W (NOISE_W),
    .B_W (K_W)
  ) u_var_lane (
    .clk    (clk),
    .ctl    (mul_ctl),
    .mcand  (pp_r),
    .mplier (k_comp),
    .prod   (prod_var)
  );

  // Control state, trajectory, estimates and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      started_r   <= 1'b0;
      q_noise_r   <= Q_RESET;
      r_noise_r   <= R_RESET;
      ev_r        <= ONE_VAR;
      for (int i = 0; i < NUM_AXES; i++) begin
        path_r[i] <= '0;
        est_r[i]  <= '0;
      end
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;

      // register writes
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_PROCESS_NOISE:     q_noise_r <= cfg_data;
          REG_MEASUREMENT_NOISE: r_noise_r <= cfg_data;
          default: ;
        endcase
      end

      // advance the raw trajectory on each input transaction
      if (in_fire) begin
        for (int i = 0; i < NUM_AXES; i++) begin
          path_r[i] <= path_r[i] + ACC_WIDTH'(shift_in[i]);
        end
      end

      // commit the filter update, or prime it on the first frame
      if (state_r == S_UPD) begin
        if (started_r) begin
          for (int i = 0; i < NUM_AXES; i++) begin
            est_r[i] <= neg_r[i] ? est_r[i] - step_d[i] : est_r[i] + step_d[i];
          end
          ev_r <= prod_var[COV_FRAC_BITS +: NOISE_W];
        end else begin
          for (int i = 0; i < NUM_AXES; i++) begin
            est_r[i] <= '0;
          end
          ev_r      <= ONE_VAR;
          started_r <= 1'b1;
        end
      end

      // output handshake
      if ((state_r == S_FIN) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working and output payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        shift_r[i] <= shift_in[i];
      end
      pp_r <= pp_sat;
    end
    if (state_r == S_PREP) begin
      den_r <= {1'b0, pp_r} + {1'b0, r_noise_r};
      for (int i = 0; i < NUM_AXES; i++) begin
        res_r[i] <= res_sat[i];
      end
    end
    // take magnitudes once the residuals are settled
    if ((state_r == S_DIV) && (cnt_r == '0)) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        neg_r[i] <= res_r[i][ACC_WIDTH-1];
        mag_r[i] <= res_r[i][ACC_WIDTH-1] ? (~res_r[i] + ACC_WIDTH'(1)) : res_r[i];
      end
    end
    if (state_r == S_LOAD) begin
      k_r <= k_sel;
    end
    if (state_r == S_DIFF) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        dev_r[i] <= DEV_W'(est_r[i]) - DEV_W'(path_r[i]);
      end
    end
    if ((state_r == S_FIN) && out_free) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        out_corr_r[i]   <= cor_sat[i];
        out_smooth_r[i] <= SMOOTH_W'(est_r[i]);
      end
      out_clip_r <= clip_any;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_corrected_x     = out_corr_r[0];
  assign out_corrected_y     = out_corr_r[1];
  assign out_corrected_angle = out_corr_r[2];
  assign out_smooth_x        = out_smooth_r[0];
  assign out_smooth_y        = out_smooth_r[1];
  assign out_smooth_angle    = out_smooth_r[2];
  assign out_clipped         = out_clip_r;

  // A new result appears only from the final state
  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result raised outside the final state");

  // The gain never exceeds one
  a_gain_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD) |=> (k_r <= ONE_K))
    else $error("gain above one");

  // The updated variance never exceeds the predicted variance
  a_var_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_UPD) && started_r) |=> (ev_r <= $past(pp_r)))
    else $error("variance grew in the update");

  // The prepare state follows an input transaction and stalls the input
  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PREP) |-> in_stall && $past(in_fire))
    else $error("frame start without an input transaction");

endmodule

// ----- test/kalman_trajectory_smoother_top_test.sv -----
// Self-checking testbench for the Kalman trajectory smoother top level.
module kalman_trajectory_smoother_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COV_FRAC       = 30;
  localparam int unsigned ACC_W          = 48;
  localparam int unsigned NUM_AXES       = kts_pkg::NUM_AXES;
  localparam int unsigned IDX_W          = kts_pkg::CFG_IDX_W;
  localparam int unsigned CLK_PERIOD     = 12;
  localparam int unsigned FRAME_LATENCY  = 2 * COV_FRAC + 8;
  localparam int unsigned HOLD_CYCLES    = 800;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned PHASES         = 12;
  localparam int unsigned PHASE_FRAMES   = 120;

  localparam logic [63:0]        UNITY_GAIN = 64'd1 << COV_FRAC;
  localparam logic signed [63:0] RESID_MAX  = (64'sd1 <<< (ACC_W - 1)) - 64'sd1;
  localparam logic signed [63:0] RESID_MIN  = -(64'sd1 <<< (ACC_W - 1));
  localparam logic signed [63:0] CORR_MAX   = 64'sd2147483647;
  localparam logic signed [63:0] CORR_MIN   = -64'sd2147483648;
  localparam logic signed [31:0] SHIFT_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SHIFT_MIN  = 32'sh8000_0000;
  localparam logic [31:0]        NOISE_MAX  = 32'hFFFF_FFFF;

  // Indexes beyond the register list
  localparam logic [IDX_W-1:0] REG_SPARE = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_TOP   = '1;

  typedef enum int {MOTION_MIXED, MOTION_PAN} motion_style_t;

  typedef struct {
    logic [NUM_AXES-1:0][31:0] corrected;
    logic [NUM_AXES-1:0][47:0] smooth;
    logic                      clipped;
  } motion_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [31:0] in_shift_x;
  logic signed [31:0] in_shift_y;
  logic signed [31:0] in_shift_angle;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_corrected_x;
  logic signed [31:0] out_corrected_y;
  logic signed [31:0] out_corrected_angle;
  logic signed [47:0] out_smooth_x;
  logic signed [47:0] out_smooth_y;
  logic signed [47:0] out_smooth_angle;
  logic out_clipped;
  logic cfg_valid;
  logic cfg_ready;
  logic [kts_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [kts_pkg::NOISE_W-1:0] cfg_data;

  // Predictor state: raw path, smoothed estimate, shared variance, noise settings
  logic signed [63:0] path_pos [NUM_AXES];
  logic signed [63:0] smooth_pos [NUM_AXES];
  logic [31:0]        shared_var;
  logic               primed;
  logic [31:0]        q_noise;
  logic [31:0]        r_noise;

  motion_result_t expected_frames [$];
  int unsigned    mismatch_count = 0;
  int unsigned    idle_cycles = 0;
  bit             calm = 1'b0;
  bit             hold_request = 1'b0;

  kalman_trajectory_smoother_top #(
    .COV_FRAC_BITS(COV_FRAC),
    .ACC_WIDTH    (ACC_W)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_shift_x         (in_shift_x),
    .in_shift_y         (in_shift_y),
    .in_shift_angle     (in_shift_angle),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_corrected_x    (out_corrected_x),
    .out_corrected_y    (out_corrected_y),
    .out_corrected_angle(out_corrected_angle),
    .out_smooth_x       (out_smooth_x),
    .out_smooth_y       (out_smooth_y),
    .out_smooth_angle   (out_smooth_angle),
    .out_clipped        (out_clipped),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Restore the predictor to its post-reset state
  function automatic void clear_trajectory();
    for (int axis = 0; axis < NUM_AXES; axis++) begin
      path_pos[axis]   = '0;
      smooth_pos[axis] = '0;
    end
    shared_var = UNITY_GAIN[31:0];
    primed     = 1'b0;
    q_noise    = kts_pkg::Q_RESET_Q30;
    r_noise    = kts_pkg::R_RESET_Q30;
  endfunction

  // Advance the trajectory by one frame and work out the expected result
  function automatic motion_result_t advance_trajectory(logic signed [31:0] dx,
                                                        logic signed [31:0] dy,
                                                        logic signed [31:0] da);
    logic signed [63:0] shift [NUM_AXES];
    logic signed [63:0] sum;
    logic signed [63:0] resid;
    logic signed [63:0] corr;
    logic [32:0]        prior_var;
    logic [33:0]        denom;
    logic [63:0]        gain;
    logic [63:0]        mag;
    logic [63:0]        delta;
    logic [63:0]        var_full;
    logic [127:0]       product;
    motion_result_t     res;
    shift[0] = dx;
    shift[1] = dy;
    shift[2] = da;
    res.clipped = 1'b0;
    // Accumulate the raw path, wrapping at the accumulator width
    for (int axis = 0; axis < NUM_AXES; axis++) begin
      sum = path_pos[axis] + shift[axis];
      path_pos[axis] = $signed(sum[ACC_W-1:0]);
    end
    if (!primed) begin
      for (int axis = 0; axis < NUM_AXES; axis++) smooth_pos[axis] = '0;
      shared_var = UNITY_GAIN[31:0];
      primed     = 1'b1;
    end else begin
      // Predicted variance saturates at 32 bits; zero denominator gives no gain
      prior_var = {1'b0, shared_var} + {1'b0, q_noise};
      if (prior_var[32]) prior_var = {1'b0, NOISE_MAX};
      denom = {1'b0, prior_var} + {2'b0, r_noise};
      if (denom == '0) gain = '0;
      else gain = ({31'd0, prior_var} << COV_FRAC) / {30'd0, denom};
      if (gain > UNITY_GAIN) gain = UNITY_GAIN;
      for (int axis = 0; axis < NUM_AXES; axis++) begin
        resid = path_pos[axis] - smooth_pos[axis];
        if (resid > RESID_MAX) resid = RESID_MAX;
        if (resid < RESID_MIN) resid = RESID_MIN;
        if (resid < 0) mag = -resid;
        else mag = resid;
        // Scale the magnitude so the step rounds toward zero
        product = {64'd0, mag} * {64'd0, gain};
        delta   = product[COV_FRAC +: 64];
        if (resid < 0) smooth_pos[axis] = smooth_pos[axis] - $signed(delta);
        else smooth_pos[axis] = smooth_pos[axis] + $signed(delta);
      end
      var_full   = (UNITY_GAIN - gain) * {31'd0, prior_var};
      shared_var = var_full[COV_FRAC +: 32];
    end
    // Corrected motion saturates to 32 bits and raises the flag
    for (int axis = 0; axis < NUM_AXES; axis++) begin
      corr = smooth_pos[axis] - path_pos[axis] + shift[axis];
      if (corr > CORR_MAX) begin
        corr = CORR_MAX;
        res.clipped = 1'b1;
      end else if (corr < CORR_MIN) begin
        corr = CORR_MIN;
        res.clipped = 1'b1;
      end
      res.corrected[axis] = corr[31:0];
      res.smooth[axis]    = smooth_pos[axis][47:0];
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch on %s: got %0h, expected %0h", what, got, want);
    mismatch_count++;
  endtask

  // Stall length: mostly short, now and then long
  function automatic int unsigned stall_length();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return $urandom_range(1, 3);
    if (pick < 95) return $urandom_range(4, 16);
    return $urandom_range(40, 200);
  endfunction

  function automatic int unsigned input_gap();
    if (calm || $urandom_range(0, 9) < 4) return 0;
    return stall_length();
  endfunction

  function automatic logic signed [31:0] random_shift(motion_style_t style,
                                                     logic signed [31:0] base);
    logic signed [31:0] jitter;
    jitter = $signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000;
    if (style == MOTION_PAN) return base + jitter;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $signed($urandom_range(0, 32'h1F_FFFF)) - 32'sh10_0000;
      4, 5, 6:    return $signed($urandom);
      7:          return $signed($urandom_range(0, 32'h7FF_FFFF)) - 32'sh400_0000;
      default: begin
        case ($urandom_range(0, 4))
          0:       return SHIFT_MAX;
          1:       return SHIFT_MIN;
          2:       return 32'sd0;
          3:       return -32'sd1;
          default: return 32'sd1;
        endcase
      end
    endcase
  endfunction

  // Offer one frame and predict its result once the transaction is taken
  task automatic send_motion(logic signed [31:0] dx, logic signed [31:0] dy,
                             logic signed [31:0] da);
    int unsigned gap;
    gap = input_gap();
    @(negedge clk);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) begin
        in_shift_x     = $urandom;
        in_shift_y     = $urandom;
        in_shift_angle = $urandom;
        @(negedge clk);
      end
    end
    in_shift_x     = dx;
    in_shift_y     = dy;
    in_shift_angle = da;
    in_valid       = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_frames.insert(expected_frames.size(), advance_trajectory(dx, dy, da));
  endtask

  // Drop the input and wait until every pending frame has come back
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_frames.size() != 0) @(negedge clk);
  endtask

  task automatic write_noise(logic [kts_pkg::CFG_IDX_W-1:0] index, logic [31:0] value);
    wait_idle();
    cfg_index = index;
    cfg_data  = value;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (index == kts_pkg::REG_PROCESS_NOISE) q_noise = value;
    else if (index == kts_pkg::REG_MEASUREMENT_NOISE) r_noise = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic test_first_frame();
    send_motion(SHIFT_MAX, SHIFT_MIN, 32'sd0);
  endtask

  task automatic test_extreme_motion();
    repeat (3) send_motion(SHIFT_MAX, SHIFT_MAX, SHIFT_MAX);
    repeat (3) send_motion(SHIFT_MIN, SHIFT_MIN, SHIFT_MIN);
    send_motion(32'sd0, -32'sd1, 32'sd1);
    send_motion(32'sd1, 32'sd0, -32'sd1);
    send_motion(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0001_0000);
  endtask

  // Zero noise drives the variance to zero, then the denominator is zero
  task automatic test_zero_denominator();
    write_noise(kts_pkg::REG_PROCESS_NOISE, 32'd0);
    write_noise(kts_pkg::REG_MEASUREMENT_NOISE, 32'd0);
    repeat (3) send_motion($urandom, $urandom, $urandom);
  endtask

  task automatic test_variance_saturation();
    write_noise(kts_pkg::REG_PROCESS_NOISE, NOISE_MAX);
    write_noise(kts_pkg::REG_MEASUREMENT_NOISE, NOISE_MAX);
    repeat (2) send_motion($urandom, $urandom, $urandom);
    write_noise(kts_pkg::REG_MEASUREMENT_NOISE, 32'd0);
    repeat (2) send_motion($urandom, $urandom, $urandom);
  endtask

  task automatic test_ignored_index();
    write_noise(REG_SPARE, $urandom);
    write_noise(REG_TOP, $urandom);
    repeat (2) send_motion($urandom, $urandom, $urandom);
    write_noise(kts_pkg::REG_PROCESS_NOISE, kts_pkg::Q_RESET_Q30);
    write_noise(kts_pkg::REG_MEASUREMENT_NOISE, kts_pkg::R_RESET_Q30);
  endtask

  // Hold the result side while frames keep coming, so the input backs up
  task automatic test_back_pressure();
    wait_idle();
    calm = 1'b1;
    hold_request = 1'b1;
    repeat (8) send_motion(random_shift(MOTION_MIXED, 0), random_shift(MOTION_MIXED, 0),
                           random_shift(MOTION_MIXED, 0));
    calm = 1'b0;
  endtask

  task automatic test_calm_stream();
    calm = 1'b1;
    repeat (60) send_motion(random_shift(MOTION_MIXED, 0), random_shift(MOTION_MIXED, 0),
                            random_shift(MOTION_MIXED, 0));
    calm = 1'b0;
  endtask

  task automatic test_random_settings();
    logic [31:0]        q_value;
    logic [31:0]        r_value;
    logic signed [31:0] pan [NUM_AXES];
    motion_style_t      style;
    int unsigned        pick;
    for (int phase = 0; phase < PHASES; phase++) begin
      pick = (phase < 2) ? phase : $urandom_range(0, 6);
      case (pick)
        0: begin q_value = kts_pkg::Q_RESET_Q30; r_value = kts_pkg::R_RESET_Q30; end
        1: begin q_value = NOISE_MAX;             r_value = NOISE_MAX;             end
        2: begin q_value = $urandom_range(0, 32'hFF_FFFF); r_value = $urandom;   end
        3: begin q_value = 32'd0;                 r_value = NOISE_MAX;             end
        4: begin q_value = NOISE_MAX;             r_value = 32'd0;                 end
        5: begin q_value = $urandom_range(0, 32'hFFFF); r_value = $urandom_range(0, 32'hFFFF); end
        default: begin q_value = $urandom; r_value = $urandom; end
      endcase
      write_noise(kts_pkg::REG_PROCESS_NOISE, q_value);
      write_noise(kts_pkg::REG_MEASUREMENT_NOISE, r_value);
      if ($urandom_range(0, 3) == 0)
        write_noise(IDX_W'($urandom_range(2, 255)), $urandom);
      // Alternate jittery camera pans with unstructured motion
      style = (phase % 2 == 1) ? MOTION_PAN : MOTION_MIXED;
      for (int axis = 0; axis < NUM_AXES; axis++)
        pan[axis] = $signed($urandom_range(0, 32'h3FF_FFFF)) - 32'sh200_0000;
      repeat (PHASE_FRAMES)
        send_motion(random_shift(style, pan[0]), random_shift(style, pan[1]),
                    random_shift(style, pan[2]));
    end
  endtask

  task automatic finish_run();
    wait_idle();
    repeat (FRAME_LATENCY) @(posedge clk);
    if (mismatch_count == 0 && expected_frames.size() == 0)
      $display("kalman_trajectory_smoother_top test passed");
    else
      $display("kalman_trajectory_smoother_top test failed");
    $finish;
  endtask

  // Result-side stalls: random stretches, or one long hold on request
  initial begin : result_stall
    int unsigned left;
    left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall    = 1'b1;
        left         = HOLD_CYCLES;
      end else if (left != 0) begin
        left--;
      end else if (calm) begin
        out_stall = 1'b0;
      end else if (out_stall) begin
        out_stall = 1'b0;
        left      = $urandom_range(0, 30);
      end else begin
        out_stall = 1'b1;
        left      = stall_length() - 1;
      end
    end
  end

  // Compare each result transaction with the oldest pending frame
  always @(posedge clk) begin : check_results
    motion_result_t            want;
    logic [NUM_AXES-1:0][31:0] got_corrected;
    logic [NUM_AXES-1:0][47:0] got_smooth;
    string                     axis_name [NUM_AXES];
    axis_name = '{"x", "y", "angle"};
    if (rst_n && out_valid && !out_stall) begin
      got_corrected = {out_corrected_angle, out_corrected_y, out_corrected_x};
      got_smooth    = {out_smooth_angle, out_smooth_y, out_smooth_x};
      if (expected_frames.size() == 0) begin
        report_mismatch("result with no frame pending", '0, '0);
      end else begin
        want = expected_frames.pop_front();
        for (int axis = 0; axis < NUM_AXES; axis++) begin
          if (got_corrected[axis] !== want.corrected[axis])
            report_mismatch({"corrected_", axis_name[axis]}, got_corrected[axis],
                            want.corrected[axis]);
          if (got_smooth[axis] !== want.smooth[axis])
            report_mismatch({"smooth_", axis_name[axis]}, got_smooth[axis],
                            want.smooth[axis]);
        end
        if (out_clipped !== want.clipped)
          report_mismatch("clipped", out_clipped, want.clipped);
      end
    end
  end

  // End the run when no transaction moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d frames pending", expected_frames.size());
      $display("kalman_trajectory_smoother_top test failed");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_shift_x     = '0;
    in_shift_y     = '0;
    in_shift_angle = '0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    clear_trajectory();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_first_frame();
    test_extreme_motion();
    test_zero_denominator();
    test_variance_saturation();
    test_ignored_index();
    test_back_pressure();
    test_calm_stream();
    test_random_settings();
    finish_run();
  end

endmodule
